// ----- rtl/rrtss_pkg.sv -----
// ----------------------------------------------------------------------------
// Round-robin scheduler package
// Shared types and constants for the round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
package rrtss_pkg;

    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] TIME_SLOT_RESET = 16'd2;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_SLICE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } dp_status_t;

endpackage

// ----- rtl/rrtss_dp.sv -----
// ----------------------------------------------------------------------------
// Round-robin scheduler datapath
// Task ring memory, head and tail pointers, task count, time slot register
// and the result registers.
// ----------------------------------------------------------------------------
module rrtss_dp #(
    parameter int RING_DEPTH = 16,
    parameter int TIME_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rrtss_pkg::CFG_W-1:0]       cfg_wdata,
    input  rrtss_pkg::ctrl_cmd_t              cmd,
    output rrtss_pkg::dp_status_t             dp_status,
    input  logic                              command,
    input  logic [TIME_WIDTH-1:0]             burst_time,
    output logic [1:0]                        status,
    output logic [TIME_WIDTH-1:0]             served_time,
    output logic [TIME_WIDTH-1:0]             left_time,
    output logic                              finished,
    output logic [$clog2(RING_DEPTH+1)-1:0]   occupancy
);
    import rrtss_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

    logic [TIME_WIDTH-1:0] ring_mem [RING_DEPTH];
    logic [TIME_WIDTH-1:0] rd_data_reg;

    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CFG_W-1:0]      slot_reg;

    logic                  cmd_reg;
    logic [TIME_WIDTH-1:0] burst_reg;

    status_t               status_reg, status_next;
    logic [TIME_WIDTH-1:0] served_reg, served_next;
    logic [TIME_WIDTH-1:0] left_reg, left_next;
    logic                  finished_reg, finished_next;
    logic [CNT_W-1:0]      occ_reg;

    logic                  ring_we;
    logic [TIME_WIDTH-1:0] wr_data;
    logic [TIME_WIDTH-1:0] slot;
    logic                  is_full;
    logic                  is_empty;

    assign slot     = TIME_WIDTH'(slot_reg);
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        res = (idx == LAST_IDX) ? '0 : idx + 1'b1;
        return res;
    endfunction

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        ring_we       = 1'b0;
        wr_data       = burst_reg;
        status_next   = ST_DONE;
        served_next   = '0;
        left_next     = '0;
        finished_next = 1'b0;
        if (cmd_reg == CMD_ADD)
        begin
            if (is_full)
            begin
                status_next = ST_OVERFLOW;
            end
            else
            begin
                ring_we    = 1'b1;
                tail_next  = ring_next(tail_reg);
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            if (is_empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                served_next = rd_data_reg;
                head_next   = ring_next(head_reg);
                if (rd_data_reg > slot)
                begin
                    left_next = rd_data_reg - slot;
                    wr_data   = rd_data_reg - slot;
                    ring_we   = 1'b1;
                    tail_next = ring_next(tail_reg);
                end
                else
                begin
                    finished_next = 1'b1;
                    count_next    = count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            slot_reg  <= TIME_SLOT_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                slot_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && ring_we)
        begin
            ring_mem[tail_reg] <= wr_data;
        end
        rd_data_reg <= ring_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= command;
            burst_reg <= burst_time;
        end
        if (cmd.exec)
        begin
            status_reg   <= status_next;
            served_reg   <= served_next;
            left_reg     <= left_next;
            finished_reg <= finished_next;
            occ_reg      <= count_next;
        end
    end

    assign dp_status.full  = is_full;
    assign dp_status.empty = is_empty;

    assign status      = status_reg;
    assign served_time = served_reg;
    assign left_time   = left_reg;
    assign finished    = finished_reg;
    assign occupancy   = occ_reg;

endmodule

// ----- rtl/rrtss_ctrl.sv -----
// ----------------------------------------------------------------------------
// Round-robin scheduler controller
// Sequences each word through capture and execution and owns the result
// valid flag.
// ----------------------------------------------------------------------------
module rrtss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 task_valid,
    output logic                 task_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    output rrtss_pkg::ctrl_cmd_t cmd
);
    import rrtss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        out_valid_next = out_valid_reg && result_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (task_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign task_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

// ----- rtl/round_robin_time_slice_scheduler.sv -----
// ----------------------------------------------------------------------------
// Round-robin time-slice scheduler
// Circular task queue that adds tasks at the tail and runs time slices on
// the head task, requeuing it while time remains.
// ----------------------------------------------------------------------------
// Each word is first captured while the head entry is read from the ring
// memory, and then executed to update the ring and load the result
// register. The registered memory read is why capture and execution are
// separate states. A finished result waits in its output register while the
// next word is captured; the block holds a word in execution only while the
// previous result is still stalled. A slice command with time left writes the
// reduced time back at the tail in the same cycle that the head advances, so
// a full ring never overflows on a slice.
module round_robin_time_slice_scheduler #(
    parameter int RING_DEPTH = 16,
    parameter int TIME_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rrtss_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                              task_valid,
    output logic                              task_stall,
    input  logic                              command,
    input  logic [TIME_WIDTH-1:0]             burst_time,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [1:0]                        status,
    output logic [TIME_WIDTH-1:0]             served_time,
    output logic [TIME_WIDTH-1:0]             left_time,
    output logic                              finished,
    output logic [$clog2(RING_DEPTH+1)-1:0]   occupancy
);
    import rrtss_pkg::*;

    localparam int OCC_W = $clog2(RING_DEPTH + 1);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    rrtss_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .task_valid   (task_valid),
        .task_stall   (task_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    rrtss_dp #(
        .RING_DEPTH (RING_DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .dp_status   (dp_status),
        .command     (command),
        .burst_time  (burst_time),
        .status      (status),
        .served_time (served_time),
        .left_time   (left_time),
        .finished    (finished),
        .occupancy   (occupancy)
    );

    a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(dp_status.full && dp_status.empty))
        else $error("Ring reported full and empty at once.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (task_valid && !task_stall) |=> task_stall)
        else $error("A new word was accepted before the previous one executed.");

    a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> result_valid)
        else $error("An executed word did not present a result.");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (occupancy <= OCC_W'(RING_DEPTH)))
        else $error("Reported occupancy exceeds the ring depth.");

endmodule

// ----- sim/slice_result_checker.sv -----
// ----------------------------------------------------------------------------
// Slice result checker
// Watches the task and result channels of the round-robin time-slice
// scheduler, keeps its own copy of the task ring and the time slot, predicts
// the result of every accepted word and compares it field by field with the
// result the block returns.
// ----------------------------------------------------------------------------
module slice_result_checker
    import rrtss_pkg::*;
#(
    parameter int RING_DEPTH = 16,
    parameter int TIME_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [CFG_W-1:0]                  cfg_wdata,
    input  logic                              task_valid,
    input  logic                              task_stall,
    input  logic                              command,
    input  logic [TIME_WIDTH-1:0]             burst_time,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  logic [1:0]                        status,
    input  logic [TIME_WIDTH-1:0]             served_time,
    input  logic [TIME_WIDTH-1:0]             left_time,
    input  logic                              finished,
    input  logic [$clog2(RING_DEPTH+1)-1:0]   occupancy,
    output int                                mismatch_count,
    output int                                words_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OCC_W = $clog2(RING_DEPTH + 1);

    typedef struct {
        status_t               status;
        logic [TIME_WIDTH-1:0] served;
        logic [TIME_WIDTH-1:0] left;
        logic                  finished;
        logic [OCC_W-1:0]      occupancy;
    } slice_result_t;

    logic [TIME_WIDTH-1:0] task_times [RING_DEPTH];
    int unsigned           head_pos;
    int unsigned           tail_pos;
    int unsigned           held_tasks;
    logic [CFG_W-1:0]      slot_length;
    slice_result_t         expected_results [$];

    function automatic int unsigned ring_advance(input int unsigned pos);
        return (pos + 1 >= RING_DEPTH) ? 0 : pos + 1;
    endfunction

    function automatic slice_result_t schedule_word(input logic cmd,
                                                    input logic [TIME_WIDTH-1:0] burst);
        slice_result_t         r;
        logic [TIME_WIDTH-1:0] slot;
        r.status   = ST_DONE;
        r.served   = '0;
        r.left     = '0;
        r.finished = 1'b0;
        slot       = TIME_WIDTH'(slot_length);
        if (cmd == CMD_ADD)
        begin
            if (held_tasks >= RING_DEPTH)
            begin
                r.status = ST_OVERFLOW;
            end
            else
            begin
                task_times[tail_pos] = burst;
                tail_pos = ring_advance(tail_pos);
                held_tasks++;
            end
        end
        else if (held_tasks == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            // The head leaves before the tail is written, so a full ring
            // always has room for the requeued task.
            r.served = task_times[head_pos];
            head_pos = ring_advance(head_pos);
            held_tasks--;
            if (r.served > slot)
            begin
                r.left = r.served - slot;
                task_times[tail_pos] = r.left;
                tail_pos = ring_advance(tail_pos);
                held_tasks++;
            end
            else
            begin
                r.finished = 1'b1;
            end
        end
        r.occupancy = OCC_W'(held_tasks);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 40)
        begin
            $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        slice_result_t want;
        if (!rst_n)
        begin
            head_pos    = 0;
            tail_pos    = 0;
            held_tasks  = 0;
            slot_length = TIME_SLOT_RESET;
            expected_results.delete();
            words_in_flight <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                slot_length = cfg_wdata;
            end
            if (task_valid && !task_stall)
            begin
                expected_results.push_back(schedule_word(command, burst_time));
            end
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result word", 32'(status), 32'h0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(status), 32'(want.status));
                    check_field("served_time", 32'(served_time), 32'(want.served));
                    check_field("left_time", 32'(left_time), 32'(want.left));
                    check_field("finished", 32'(finished), 32'(want.finished));
                    check_field("occupancy", 32'(occupancy), 32'(want.occupancy));
                end
            end
            words_in_flight <= expected_results.size();
        end
    end

endmodule

// ----- sim/round_robin_time_slice_scheduler_test.sv -----
// ----------------------------------------------------------------------------
// Round-robin time-slice scheduler testbench
// Drives directed and random add and slice words into the scheduler under
// several time slot settings, with random gaps on the sender and random
// stalls on the receiver. A separate checker predicts and compares every
// result; this module gives the verdict.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rrtss_pkg::*;

    localparam int RING_DEPTH = 16;
    localparam int TIME_WIDTH = 16;
    localparam int OCC_W      = $clog2(RING_DEPTH + 1);

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  task_valid;
    logic                  task_stall;
    logic                  command;
    logic [TIME_WIDTH-1:0] burst_time;
    logic                  result_valid;
    logic                  result_stall;
    logic [1:0]            status;
    logic [TIME_WIDTH-1:0] served_time;
    logic [TIME_WIDTH-1:0] left_time;
    logic                  finished;
    logic [OCC_W-1:0]      occupancy;
    int                    mismatch_count;
    int                    words_in_flight;
    bit                    gaps_enabled;
    int                    current_slot;

    round_robin_time_slice_scheduler #(
        .RING_DEPTH (RING_DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .task_valid   (task_valid),
        .task_stall   (task_stall),
        .command      (command),
        .burst_time   (burst_time),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .served_time  (served_time),
        .left_time    (left_time),
        .finished     (finished),
        .occupancy    (occupancy)
    );

    slice_result_checker #(
        .RING_DEPTH (RING_DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .task_valid      (task_valid),
        .task_stall      (task_stall),
        .command         (command),
        .burst_time      (burst_time),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .status          (status),
        .served_time     (served_time),
        .left_time       (left_time),
        .finished        (finished),
        .occupancy       (occupancy),
        .mismatch_count  (mismatch_count),
        .words_in_flight (words_in_flight)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_word(input logic cmd, input logic [TIME_WIDTH-1:0] burst);
        int gap;
        gap = gaps_enabled ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            task_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        task_valid <= 1'b1;
        command    <= cmd;
        burst_time <= burst;
        @(posedge clk);
        while (task_stall) @(posedge clk);
    endtask

    task automatic wait_for_idle();
        task_valid <= 1'b0;
        @(posedge clk);
        while (words_in_flight != 0) @(posedge clk);
    endtask

    task automatic write_time_slot(input int value);
        wait_for_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        current_slot = value;
    endtask

    function automatic logic [TIME_WIDTH-1:0] draw_burst();
        int pick;
        int limit;
        pick  = $urandom_range(0, 7);
        limit = current_slot * 4;
        if (limit > 65535)
        begin
            limit = 65535;
        end
        case (pick)
            0, 1:    return TIME_WIDTH'($urandom);
            2:       return '0;
            3:       return '1;
            4, 5:    return TIME_WIDTH'($urandom_range(0, 15));
            default: return TIME_WIDTH'($urandom_range(0, limit));
        endcase
    endfunction

    // The receiver draws a stall length for every result word.
    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = gaps_enabled ? $urandom_range(0, 12) : 0;
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [TIME_WIDTH-1:0] fill_times [16];
        int                    slot_choices [6];
        int                    add_percent;
        fill_times = '{16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001, 16'h0002, 16'h0003,
                       16'h8000, 16'h7FFF, 16'h0000, 16'h0004, 16'h0005, 16'h00FF,
                       16'hFF00, 16'h0010, 16'h1234, 16'hFFFE};
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        task_valid   = 1'b0;
        command      = CMD_ADD;
        burst_time   = '0;
        result_stall = 1'b0;
        gaps_enabled = 1'b1;
        current_slot = int'(TIME_SLOT_RESET);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(CMD_SLICE, 16'h1234);
        send_word(CMD_ADD, 16'h0000);
        send_word(CMD_SLICE, 16'h0000);
        send_word(CMD_ADD, 16'h0003);
        send_word(CMD_SLICE, 16'hFFFF);
        send_word(CMD_SLICE, 16'h0000);
        for (int i = 0; i < 16; i++)
        begin
            send_word(CMD_ADD, fill_times[i]);
        end
        send_word(CMD_ADD, 16'h4321);
        send_word(CMD_SLICE, 16'h0000);

        slot_choices = '{1, 65535, 3, $urandom_range(1, 16), $urandom_range(1, 65535), 2};
        for (int phase = 0; phase < 6; phase++)
        begin
            write_time_slot(slot_choices[phase]);
            add_percent = $urandom_range(35, 70);
            for (int n = 0; n < 100; n++)
            begin
                if (n % 25 == 0)
                begin
                    gaps_enabled = ($urandom_range(0, 3) != 0);
                end
                if ($urandom_range(0, 99) < add_percent)
                begin
                    send_word(CMD_ADD, draw_burst());
                end
                else
                begin
                    send_word(CMD_SLICE, TIME_WIDTH'($urandom));
                end
            end
        end

        wait_for_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- round_robin_time_slice_scheduler.f -----
rtl/rrtss_pkg.sv
rtl/rrtss_dp.sv
rtl/rrtss_ctrl.sv
rtl/round_robin_time_slice_scheduler.sv
sim/slice_result_checker.sv
sim/round_robin_time_slice_scheduler_test.sv
